// ===== design/mecanum_wheel_speed_mixer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Mecanum mixer assertion macros
// Shared assertion forms, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_MIXER_TOP_MACROS_SVH
`define MECANUM_WHEEL_SPEED_MIXER_TOP_MACROS_SVH

// condition holds at every sampled edge
`define MWSM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mixer assertion failed");

// antecedent implies consequent at the same edge
`define MWSM_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mixer assertion failed");

// antecedent implies consequent after the delay given by dly
`define MWSM_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error("mixer assertion failed");

`endif

// ===== design/mwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer package
// Widths, register indexes, reset values and inter-stage types.
// ----------------------------------------------------------------------------
package mwsm_pkg;

    localparam int SPD_W      = 16;
    localparam int FACTOR_W   = 16;
    localparam int LIMIT_W    = 15;
    localparam int MAP_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_WHEELS = 4;

    // pipeline depth: mixer, limiter, one divider step per quotient bit, output
    localparam int MIX_STAGES = 3;
    localparam int LIM_STAGES = 3;
    localparam int DIV_STEPS  = 16;
    localparam int LATENCY    = MIX_STAGES + LIM_STAGES + DIV_STEPS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_TO_RPM   = 3'd0,
        CFG_TURN_TO_RPM    = 3'd1,
        CFG_RPM_LIMIT      = 3'd2,
        CFG_REVERSE_ALL    = 3'd3,
        CFG_WHEEL_MAP      = 3'd4,
        CFG_LATERAL_ENABLE = 3'd5
    } t_cfg_idx;

    localparam logic [FACTOR_W-1:0] RST_SPEED_TO_RPM = 16'd256;
    localparam logic [FACTOR_W-1:0] RST_TURN_TO_RPM  = 16'd256;
    localparam logic [LIMIT_W-1:0]  RST_RPM_LIMIT    = 15'd32767;
    localparam logic [MAP_W-1:0]    RST_WHEEL_MAP    = 8'd228;

    localparam logic signed [SPD_W-1:0] SPD_MAX = 16'sh7fff;
    localparam logic signed [SPD_W-1:0] SPD_MIN = 16'sh8000;

    typedef logic signed [SPD_W-1:0] t_speed;

    typedef struct packed {
        logic [FACTOR_W-1:0] speed_to_rpm;
        logic [FACTOR_W-1:0] turn_to_rpm;
        logic [LIMIT_W-1:0]  rpm_limit;
        logic                reverse_all;
        logic [MAP_W-1:0]    wheel_map;
        logic                lateral_enable;
    } t_cfg;

    // mapped and, if enabled, reversed slot speeds leaving the mixer
    typedef struct packed {
        logic                        vld;
        t_speed [NUM_WHEELS-1:0]     slot;
    } t_mix_out;

    // one divider step per stage; lo shifts dividend bits out, quotient bits in
    typedef struct packed {
        logic                              vld;
        logic                              limited;
        logic [NUM_WHEELS-1:0]             neg;
        logic [SPD_W-1:0]                  divisor;
        logic [NUM_WHEELS-1:0][SPD_W-1:0]  rem;
        logic [NUM_WHEELS-1:0][SPD_W-1:0]  lo;
    } t_div_pipe;

endpackage

// ===== design/mwsm_mix.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer front end
// Scales commands, mixes the four wheels, routes them to slots and, if enabled, reverses.
// ----------------------------------------------------------------------------
module mwsm_mix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic signed [mwsm_pkg::SPD_W-1:0] i_forward_speed,
    input  logic signed [mwsm_pkg::SPD_W-1:0] i_lateral_speed,
    input  logic signed [mwsm_pkg::SPD_W-1:0] i_turn_rate,
    input  mwsm_pkg::t_cfg                i_cfg,
    output mwsm_pkg::t_mix_out            o_mix
);
    import mwsm_pkg::*;

    // truncate a Q12.20 product to 1/16 rpm toward zero
    function automatic t_speed trunc16(input logic signed [32:0] p);
        logic signed [32:0] adj;
        adj = p[32] ? (p + 33'sd65535) : p;
        return adj[31:16];
    endfunction

    function automatic t_speed sat16(input logic signed [17:0] v);
        t_speed res;
        if (v > 18'sd32767) begin
            res = SPD_MAX;
        end else if (v < -18'sd32768) begin
            res = SPD_MIN;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // stage A: products
    logic               r_a_vld;
    logic signed [32:0] r_prod_f, r_prod_l, r_prod_w;
    logic signed [32:0] n_prod_f, n_prod_l, n_prod_w;

    // stage B: saturated wheel sums
    logic                     r_b_vld;
    t_speed [NUM_WHEELS-1:0]  r_wheel, n_wheel;

    // stage C: slots
    t_mix_out r_c, n_c;

    always_comb begin
        n_prod_f = $signed(i_forward_speed) * $signed({1'b0, i_cfg.speed_to_rpm});
        n_prod_l = $signed(i_lateral_speed) * $signed({1'b0, i_cfg.speed_to_rpm});
        n_prod_w = $signed(i_turn_rate)     * $signed({1'b0, i_cfg.turn_to_rpm});
    end

    always_comb begin
        logic signed [17:0] fe, le, we;
        fe = 18'(trunc16(r_prod_f));
        le = i_cfg.lateral_enable ? 18'(trunc16(r_prod_l)) : 18'sd0;
        we = 18'(trunc16(r_prod_w));
        n_wheel[0] = sat16( fe - le - we);
        n_wheel[1] = sat16(-fe - le - we);
        n_wheel[2] = sat16( fe + le - we);
        n_wheel[3] = sat16(-fe + le - we);
    end

    always_comb begin
        n_c.vld  = r_b_vld;
        n_c.slot = '0;
        // later wheels win a slot clash
        for (int i = 0; i < NUM_WHEELS; i++) begin
            n_c.slot[i_cfg.wheel_map[2*i +: 2]] = r_wheel[i];
        end
        if (i_cfg.reverse_all) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                n_c.slot[i] = (n_c.slot[i] == SPD_MIN) ? SPD_MAX : -n_c.slot[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c.vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c.vld <= n_c.vld;
        end
        r_prod_f <= n_prod_f;
        r_prod_l <= n_prod_l;
        r_prod_w <= n_prod_w;
        r_wheel  <= n_wheel;
        r_c.slot <= n_c.slot;
    end

    assign o_mix = r_c;

endmodule

// ===== design/mwsm_limit.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer limiter
// Finds the peak magnitude, picks the scale and forms divider operands.
// ----------------------------------------------------------------------------
module mwsm_limit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mwsm_pkg::t_mix_out            i_mix,
    input  logic [mwsm_pkg::LIMIT_W-1:0]  i_rpm_limit,
    output mwsm_pkg::t_div_pipe           o_div
);
    import mwsm_pkg::*;

    // stage D: magnitudes
    logic                                r_d_vld;
    logic [NUM_WHEELS-1:0]               r_d_neg, n_d_neg;
    logic [NUM_WHEELS-1:0][SPD_W-1:0]    r_d_mag, n_d_mag;

    // stage E: peak and scale selection
    logic                                r_e_vld;
    logic                                r_e_limited, n_e_limited;
    logic [NUM_WHEELS-1:0]               r_e_neg;
    logic [NUM_WHEELS-1:0][SPD_W-1:0]    r_e_mag;
    logic [LIMIT_W-1:0]                  r_e_mult, n_e_mult;
    logic [SPD_W-1:0]                    r_e_div, n_e_div;

    // stage F: products into the divider
    t_div_pipe r_f, n_f;

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            n_d_neg[i] = i_mix.slot[i][SPD_W-1];
            n_d_mag[i] = n_d_neg[i] ? SPD_W'(-i_mix.slot[i]) : SPD_W'(i_mix.slot[i]);
        end
    end

    always_comb begin
        logic [SPD_W-1:0] p01, p23, peak;
        p01  = (r_d_mag[0] > r_d_mag[1]) ? r_d_mag[0] : r_d_mag[1];
        p23  = (r_d_mag[2] > r_d_mag[3]) ? r_d_mag[2] : r_d_mag[3];
        peak = (p01 > p23) ? p01 : p23;
        n_e_limited = peak > {1'b0, i_rpm_limit};
        // unity scale keeps the slot unchanged through the divider
        n_e_mult = n_e_limited ? i_rpm_limit : LIMIT_W'(1);
        n_e_div  = n_e_limited ? peak : SPD_W'(1);
    end

    always_comb begin
        logic [29:0] prod;
        n_f.vld     = r_e_vld;
        n_f.limited = r_e_limited;
        n_f.neg     = r_e_neg;
        n_f.divisor = r_e_div;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            prod = {14'b0, r_e_mag[i]} * {15'b0, r_e_mult};
            n_f.rem[i] = {2'b0, prod[29:16]};
            n_f.lo[i]  = prod[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f.vld <= 1'b0;
        end else begin
            r_d_vld <= i_mix.vld;
            r_e_vld <= r_d_vld;
            r_f.vld <= n_f.vld;
        end
        r_d_neg     <= n_d_neg;
        r_d_mag     <= n_d_mag;
        r_e_limited <= n_e_limited;
        r_e_neg     <= r_d_neg;
        r_e_mag     <= r_d_mag;
        r_e_mult    <= n_e_mult;
        r_e_div     <= n_e_div;
        r_f.limited <= n_f.limited;
        r_f.neg     <= n_f.neg;
        r_f.divisor <= n_f.divisor;
        r_f.rem     <= n_f.rem;
        r_f.lo      <= n_f.lo;
    end

    assign o_div = r_f;

endmodule

// ===== design/mwsm_div_stage.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer divider step
// One restoring division step for all four lanes, registered.
// ----------------------------------------------------------------------------
module mwsm_div_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mwsm_pkg::t_div_pipe  i_p,
    output mwsm_pkg::t_div_pipe  o_p
);
    import mwsm_pkg::*;

    t_div_pipe r_p, n_p;

    always_comb begin
        logic [SPD_W:0] trial;
        logic           ge;
        n_p = i_p;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            trial = {i_p.rem[i], i_p.lo[i][SPD_W-1]};
            ge    = trial >= {1'b0, i_p.divisor};
            n_p.rem[i] = ge ? SPD_W'(trial - {1'b0, i_p.divisor}) : trial[SPD_W-1:0];
            n_p.lo[i]  = {i_p.lo[i][SPD_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p.vld <= 1'b0;
        end else begin
            r_p.vld <= n_p.vld;
        end
        r_p.limited <= n_p.limited;
        r_p.neg     <= n_p.neg;
        r_p.divisor <= n_p.divisor;
        r_p.rem     <= n_p.rem;
        r_p.lo      <= n_p.lo;
    end

    assign o_p = r_p;

endmodule

// ===== design/mecanum_wheel_speed_mixer_top.sv =====
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer
// Velocity command to four slot speeds with peak limiting.
//
//   channel   handshake            payload
//   command   start / busy         i_forward_speed, i_lateral_speed, i_turn_rate
//   result    o_done (strobe)      o_speed_slot0..3, o_was_limited
//   config    i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// One request per cycle; each result passes through 6 mixer/limiter stages,
// 16 divider steps and the output register.
// busy stays low: the pipeline never holds a request off.
// Synchronous reset clears all valid bits and loads register defaults.
// The result strobe lasts one cycle; there is no stall on either side.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [mwsm_pkg::SPD_W-1:0]     i_forward_speed,
    input  logic signed [mwsm_pkg::SPD_W-1:0]     i_lateral_speed,
    input  logic signed [mwsm_pkg::SPD_W-1:0]     i_turn_rate,
    input  logic                                  i_cfg_we,
    input  logic [mwsm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mwsm_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output logic                                  o_done,
    output logic signed [mwsm_pkg::SPD_W-1:0]     o_speed_slot0,
    output logic signed [mwsm_pkg::SPD_W-1:0]     o_speed_slot1,
    output logic signed [mwsm_pkg::SPD_W-1:0]     o_speed_slot2,
    output logic signed [mwsm_pkg::SPD_W-1:0]     o_speed_slot3,
    output logic                                  o_was_limited
);
    import mwsm_pkg::*;

    t_cfg                    r_cfg;
    t_mix_out                mix;
    t_div_pipe               div_chain [DIV_STEPS+1];

    logic                    r_done;
    logic                    r_limited;
    t_speed [NUM_WHEELS-1:0] r_speed, n_speed;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_to_rpm   <= RST_SPEED_TO_RPM;
            r_cfg.turn_to_rpm    <= RST_TURN_TO_RPM;
            r_cfg.rpm_limit      <= RST_RPM_LIMIT;
            r_cfg.reverse_all    <= 1'b0;
            r_cfg.wheel_map      <= RST_WHEEL_MAP;
            r_cfg.lateral_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPEED_TO_RPM:   r_cfg.speed_to_rpm   <= i_cfg_wdata;
                CFG_TURN_TO_RPM:    r_cfg.turn_to_rpm    <= i_cfg_wdata;
                CFG_RPM_LIMIT:      r_cfg.rpm_limit      <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_REVERSE_ALL:    r_cfg.reverse_all    <= i_cfg_wdata[0];
                CFG_WHEEL_MAP:      r_cfg.wheel_map      <= i_cfg_wdata[MAP_W-1:0];
                CFG_LATERAL_ENABLE: r_cfg.lateral_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    mwsm_mix u_mix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (start && !busy),
        .i_forward_speed (i_forward_speed),
        .i_lateral_speed (i_lateral_speed),
        .i_turn_rate     (i_turn_rate),
        .i_cfg           (r_cfg),
        .o_mix           (mix)
    );

    mwsm_limit u_limit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mix       (mix),
        .i_rpm_limit (r_cfg.rpm_limit),
        .o_div       (div_chain[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        mwsm_div_stage u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_p     (div_chain[g]),
            .o_p     (div_chain[g+1])
        );
    end

    // quotient magnitude gets the slot's sign back
    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            n_speed[i] = div_chain[DIV_STEPS].neg[i] ? -$signed(div_chain[DIV_STEPS].lo[i])
                                                     :  $signed(div_chain[DIV_STEPS].lo[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_chain[DIV_STEPS].vld;
        end
        r_limited <= div_chain[DIV_STEPS].limited;
        r_speed   <= n_speed;
    end

    assign o_done        = r_done;
    assign o_was_limited = r_limited;
    assign o_speed_slot0 = r_speed[0];
    assign o_speed_slot1 = r_speed[1];
    assign o_speed_slot2 = r_speed[2];
    assign o_speed_slot3 = r_speed[3];

endmodule

// ===== design/mwsm_chk.sv =====
// ----------------------------------------------------------------------------
// Mecanum mixer port checker
// Watches the top-level ports for busy, latency and limit violations.
// ----------------------------------------------------------------------------
`include "mecanum_wheel_speed_mixer_top_macros.svh"

module mwsm_chk (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic                                  i_cfg_we,
    input  logic [mwsm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mwsm_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                  o_done,
    input  logic signed [mwsm_pkg::SPD_W-1:0]     o_speed_slot0,
    input  logic signed [mwsm_pkg::SPD_W-1:0]     o_speed_slot1,
    input  logic signed [mwsm_pkg::SPD_W-1:0]     o_speed_slot2,
    input  logic signed [mwsm_pkg::SPD_W-1:0]     o_speed_slot3
);
    import mwsm_pkg::*;

    function automatic logic [SPD_W:0] mag(input logic [SPD_W-1:0] s);
        return s[SPD_W-1] ? ((SPD_W+1)'(1) << SPD_W) - {1'b0, s} : {1'b0, s};
    endfunction

    // shadow of the limit register, seen through the config port
    logic [LIMIT_W-1:0] r_lim;
    logic               in_range;
    logic               req_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= RST_RPM_LIMIT;
        end else if (i_cfg_we && (i_cfg_idx == CFG_RPM_LIMIT)) begin
            r_lim <= i_cfg_wdata[LIMIT_W-1:0];
        end
    end

    assign req_ok   = start && !busy;
    assign in_range = (mag(o_speed_slot0) <= {2'b0, r_lim}) &&
                      (mag(o_speed_slot1) <= {2'b0, r_lim}) &&
                      (mag(o_speed_slot2) <= {2'b0, r_lim}) &&
                      (mag(o_speed_slot3) <= {2'b0, r_lim});

    `MWSM_ASSERT_ALWAYS(a_never_busy, !busy)
    `MWSM_ASSERT_DELAY(a_req_gets_result, req_ok, LATENCY, o_done)
    `MWSM_ASSERT_IMPLIES(a_result_had_req, o_done, $past(req_ok, LATENCY))
    `MWSM_ASSERT_IMPLIES(a_within_limit, o_done, in_range)

endmodule

bind mecanum_wheel_speed_mixer_top mwsm_chk u_chk (.*);
